### hw/rtl/assert_macros.svh
// Assertion macros used by the solver checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on aclk, switched off while aresetn is low.
`define LGRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked on aclk, also checked during reset.
`define LGRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/lgrs_pkg.sv
// Types, constants and codes shared by the Laplace grid solver modules.
`timescale 1ns / 1ps
package lgrs_pkg;

    localparam int GRID_MAX   = 64;
    localparam int IDX_W      = $clog2(GRID_MAX);
    localparam int SIZE_W     = 7;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = GRID_MAX * GRID_MAX;
    localparam int VAL_W      = 24;
    localparam int SUM_W      = VAL_W + 2;
    localparam int DIV_W      = VAL_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int SWEEP_W    = 16;
    localparam int RAD_W      = 7;
    localparam int OFS_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DISC_W     = 10;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
    localparam logic [SIZE_W-1:0] GRID_MIN      = 7'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS    = 3'd6;

    localparam logic [2:0] RSEL_REQ = 3'd0;
    localparam logic [2:0] RSEL_XP  = 3'd1;
    localparam logic [2:0] RSEL_XM  = 3'd2;
    localparam logic [2:0] RSEL_YA  = 3'd3;
    localparam logic [2:0] RSEL_YB  = 3'd4;

    localparam logic ACT_RUN  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] x_index;
        logic [IDX_W-1:0] y_index;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] cell_value;
        logic                    result_kind;
    } out_item_t;

    typedef struct packed {
        logic             req_load;
        logic             div_start;
        logic             acc_init;
        logic             acc_step;
        logic [2:0]       rsel;
        logic             sum_load;
        logic             sum_add;
        logic             fill_we;
        logic             sweep_we;
        logic             out_load;
        logic             out_kind;
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
    } dp_cmd_t;

    typedef struct packed {
        logic               div_done;
        logic               out_free;
        logic [IDX_W-1:0]   n_m1;
        logic [SWEEP_W-1:0] sweeps;
    } dp_stat_t;

endpackage

### hw/rtl/laplace_grid_relaxation_solver.sv
// Top level of the Laplace grid relaxation solver.
//
// Request channel s_*: action 0 runs the solver (fill the grid, then
// sweep_count Gauss-Seidel sweeps); action 1 reads cell (x_index, y_index).
// Result channel m_*: one result per request; result_kind 0 = run done with
// cell_value 0, 1 = read data (0 if the cell lies outside the grid in use).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready, write only while no request is in flight.
// A read passes through the request register, the memory read register and
// the output register before m_valid. A run does a step divide in the
// restoring divider, one memory write per cell to fill, then four reads and
// a write per cell of columns 1 to n-2 per sweep, set by the single read port.
// One request is processed at a time; s_ready is high only when idle, while
// a finished result may still wait in the output register.
// A stalled receiver holds the result in the output register; the block
// then stops at the end of the next request until it is taken.
// Reset sets the configuration registers to their defaults and clears the
// control state and m_valid; grid contents are undefined until the first run.
`timescale 1ns / 1ps
module laplace_grid_relaxation_solver import lgrs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lgrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_data.action),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lgrs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hw/rtl/lgrs_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module lgrs_div import lgrs_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic [IDX_W-1:0]        divisor,
    output logic                    done,
    output logic signed [DIV_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic                 neg_reg;
    logic [IDX_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            neg_reg <= dividend[DIV_W-1];
            quo_reg <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
        end else if (busy_reg) begin
            rem_reg <= fits ? IDX_W'(trial - {1'b0, divisor}) : trial[IDX_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

### hw/rtl/lgrs_dp.sv
// Datapath: configuration registers, grid memory, divider, averaging and output register.
`timescale 1ns / 1ps
module lgrs_dp import lgrs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              s_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [SIZE_W-1:0]       grid_size_reg;
    logic signed [VAL_W-1:0] left_reg;
    logic signed [VAL_W-1:0] right_reg;
    logic signed [VAL_W-1:0] cyl_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic signed [OFS_W-1:0] offset_reg;
    logic [SWEEP_W-1:0]      sweeps_reg;

    in_item_t                req_reg;
    logic signed [DIV_W-1:0] acc_reg;
    logic signed [DIV_W-1:0] step_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [VAL_W-1:0]        rdata_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic [VAL_W-1:0] grid_mem [0:DEPTH-1];

    logic [SIZE_W-1:0]         n;
    logic [IDX_W-1:0]          n_m1;
    logic signed [DIV_W-1:0]   diff;
    logic                      div_done;
    logic signed [DIV_W-1:0]   quotient;
    logic signed [DISC_W-1:0]  cx;
    logic signed [DISC_W-1:0]  cy;
    logic signed [DISC_W-1:0]  dx;
    logic signed [DISC_W-1:0]  dy;
    logic [2*DISC_W:0]         dist2;
    logic [2*RAD_W-1:0]        r2;
    logic                      outside;
    logic                      on_edge;
    logic [IDX_W-1:0]          xp, xm, ya, yb;
    logic [ADDR_W-1:0]         raddr;
    logic signed [SUM_W-1:0]   rd_ext;
    logic signed [SUM_W-1:0]   total;
    logic [VAL_W-1:0]          fill_val;
    logic [VAL_W-1:0]          wdata;
    logic                      we;
    logic                      in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_SIZE_RST;
            left_reg      <= '0;
            right_reg     <= '0;
            cyl_reg       <= '0;
            radius_reg    <= '0;
            offset_reg    <= '0;
            sweeps_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GRID_SIZE: grid_size_reg <= cfg_data[SIZE_W-1:0];
                CFG_LEFT:      left_reg      <= cfg_data[VAL_W-1:0];
                CFG_RIGHT:     right_reg     <= cfg_data[VAL_W-1:0];
                CFG_CYL:       cyl_reg       <= cfg_data[VAL_W-1:0];
                CFG_RADIUS:    radius_reg    <= cfg_data[RAD_W-1:0];
                CFG_OFFSET:    offset_reg    <= cfg_data[OFS_W-1:0];
                CFG_SWEEPS:    sweeps_reg    <= cfg_data[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (grid_size_reg < GRID_MIN) begin
            n = GRID_MIN;
        end else if (grid_size_reg > SIZE_W'(GRID_MAX)) begin
            n = SIZE_W'(GRID_MAX);
        end else begin
            n = grid_size_reg;
        end
    end
    assign n_m1 = IDX_W'(n - 1'b1);

    assign diff = {right_reg[VAL_W-1], right_reg} - {left_reg[VAL_W-1], left_reg};

    lgrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (diff),
        .divisor  (n_m1),
        .done     (div_done),
        .quotient (quotient)
    );

    // Disc membership of the current cell
    assign cy      = signed'(DISC_W'(n[SIZE_W-1:1]));
    assign cx      = cy + DISC_W'(offset_reg);
    assign dx      = signed'(DISC_W'(cmd.x)) - cx;
    assign dy      = signed'(DISC_W'(cmd.y)) - cy;
    assign dist2   = (2*DISC_W+1)'(dx * dx) + (2*DISC_W+1)'(dy * dy);
    assign r2      = radius_reg * radius_reg;
    assign outside = dist2 > (2*DISC_W+1)'(r2);
    assign on_edge = (cmd.y == '0) || (cmd.y == n_m1);

    assign xp = cmd.x + 1'b1;
    assign xm = cmd.x - 1'b1;
    assign ya = (cmd.y == n_m1) ? cmd.y - 1'b1 : cmd.y + 1'b1;
    assign yb = (cmd.y == '0) ? cmd.y + 1'b1 : cmd.y - 1'b1;

    always_comb begin
        case (cmd.rsel)
            RSEL_XP: raddr = {xp, cmd.y};
            RSEL_XM: raddr = {xm, cmd.y};
            RSEL_YA: raddr = {cmd.x, ya};
            RSEL_YB: raddr = {cmd.x, yb};
            default: raddr = {req_reg.x_index, req_reg.y_index};
        endcase
    end

    assign rd_ext   = signed'({{(SUM_W-VAL_W){rdata_reg[VAL_W-1]}}, rdata_reg});
    assign total    = sum_reg + rd_ext;
    assign fill_val = (cmd.x == '0) ? left_reg : (outside ? acc_reg[VAL_W-1:0] : cyl_reg);
    assign we       = cmd.fill_we || (cmd.sweep_we && (on_edge || outside));
    assign wdata    = cmd.fill_we ? fill_val : total[SUM_W-1:2];

    always_ff @(posedge aclk) begin
        if (we) begin
            grid_mem[{cmd.x, cmd.y}] <= wdata;
        end
        rdata_reg <= grid_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_reg <= s_data;
        end
        if (cmd.acc_init) begin
            acc_reg  <= {left_reg[VAL_W-1], left_reg};
            step_reg <= quotient;
        end else if (cmd.acc_step) begin
            acc_reg <= acc_reg + step_reg;
        end
        if (cmd.sum_load) begin
            sum_reg <= rd_ext;
        end else if (cmd.sum_add) begin
            sum_reg <= total;
        end
    end

    assign in_range = ({1'b0, req_reg.x_index} < n) && ({1'b0, req_reg.y_index} < n);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.cell_value  <= (cmd.out_kind && in_range) ? rdata_reg : '0;
            m_data_reg.result_kind <= cmd.out_kind;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.n_m1     = n_m1;
    assign stat.sweeps   = sweeps_reg;

endmodule

### hw/rtl/lgrs_ctrl.sv
// Controller: request sequencing, grid fill and sweep scan counters.
`timescale 1ns / 1ps
module lgrs_ctrl import lgrs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_action,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RD_ISSUE  = 4'd1;
    localparam logic [3:0] ST_RD_DONE   = 4'd2;
    localparam logic [3:0] ST_DIV_START = 4'd3;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd4;
    localparam logic [3:0] ST_FILL      = 4'd5;
    localparam logic [3:0] ST_SW_R0     = 4'd6;
    localparam logic [3:0] ST_SW_R1     = 4'd7;
    localparam logic [3:0] ST_SW_R2     = 4'd8;
    localparam logic [3:0] ST_SW_R3     = 4'd9;
    localparam logic [3:0] ST_SW_W      = 4'd10;
    localparam logic [3:0] ST_FINISH    = 4'd11;

    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   x_reg, x_next;
    logic [IDX_W-1:0]   y_reg, y_next;
    logic [SWEEP_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]   n_m2;

    assign n_m2 = stat.n_m1 - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.rsel   = RSEL_REQ;
        cmd.x      = x_reg;
        cmd.y      = y_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = (s_action == ACT_READ) ? ST_RD_ISSUE : ST_DIV_START;
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_DONE;
            end
            ST_RD_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = ACT_READ;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.acc_init = 1'b1;
                    x_next       = '0;
                    y_next       = '0;
                    state_next   = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_we = 1'b1;
                if (y_reg == stat.n_m1) begin
                    y_next = '0;
                    if (x_reg == stat.n_m1) begin
                        x_next     = IDX_W'(1);
                        k_next     = '0;
                        state_next = (stat.sweeps == '0) ? ST_FINISH : ST_SW_R0;
                    end else begin
                        x_next       = x_reg + 1'b1;
                        cmd.acc_step = 1'b1;
                    end
                end else begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_SW_R0: begin
                cmd.rsel   = RSEL_XP;
                state_next = ST_SW_R1;
            end
            ST_SW_R1: begin
                cmd.rsel     = RSEL_XM;
                cmd.sum_load = 1'b1;
                state_next   = ST_SW_R2;
            end
            ST_SW_R2: begin
                cmd.rsel    = RSEL_YA;
                cmd.sum_add = 1'b1;
                state_next  = ST_SW_R3;
            end
            ST_SW_R3: begin
                cmd.rsel    = RSEL_YB;
                cmd.sum_add = 1'b1;
                state_next  = ST_SW_W;
            end
            ST_SW_W: begin
                cmd.sweep_we = 1'b1;
                state_next   = ST_SW_R0;
                if (y_reg == stat.n_m1) begin
                    y_next = '0;
                    if (x_reg == n_m2) begin
                        x_next = IDX_W'(1);
                        if (k_reg == stat.sweeps - 1'b1) begin
                            state_next = ST_FINISH;
                        end else begin
                            k_next = k_reg + 1'b1;
                        end
                    end else begin
                        x_next = x_reg + 1'b1;
                    end
                end else begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = ACT_RUN;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/lgrs_checker.sv
// Port-level checks on the solver, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lgrs_checker import lgrs_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `LGRS_ASSERT_ALWAYS(a_reset_no_result, !aresetn |=> !m_valid, "result valid after reset")
    `LGRS_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped")
    `LGRS_ASSERT(a_one_request, s_valid && s_ready |=> !s_ready, "request taken while busy")
    `LGRS_ASSERT(a_run_zero, m_valid && !m_data.result_kind |-> m_data.cell_value == 24'sd0, "run value")

endmodule

bind laplace_grid_relaxation_solver lgrs_checker u_lgrs_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the Laplace grid relaxation solver.
`timescale 1ns / 1ps
module testbench;
    import lgrs_pkg::*;

    localparam int WATCHDOG = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    laplace_grid_relaxation_solver dut (.*);

    always #4 aclk = ~aclk;

    // solver state as seen by the predictor
    longint grid_cells[0:DEPTH-1];
    logic [SIZE_W-1:0] size_reg = GRID_SIZE_RST;
    longint left_pot = 0, right_pot = 0, cyl_pot = 0, radius = 0, offset = 0;
    longint sweeps = 0;

    out_item_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_req = 0;
    bit calm = 0;

    function automatic longint grid_edge();
        if (size_reg < GRID_MIN) return GRID_MIN;
        if (size_reg > GRID_MAX) return GRID_MAX;
        return size_reg;
    endfunction

    function automatic bit off_disc(longint x, longint y, longint cx, longint cy);
        longint dx, dy;
        dx = x - cx;
        dy = y - cy;
        return dx * dx + dy * dy > radius * radius;
    endfunction

    task automatic fill_and_relax();
        longint n, cx, cy, stp, s;
        n = grid_edge();
        cx = n / 2 + offset;
        cy = n / 2;
        stp = (right_pot - left_pot) / (n - 1);
        for (longint y = 0; y < n; y++) grid_cells[y] = left_pot;
        for (longint x = 1; x < n; x++)
            for (longint y = 0; y < n; y++)
                grid_cells[x*GRID_MAX+y] = off_disc(x, y, cx, cy) ? left_pot + x * stp : cyl_pot;
        for (longint k = 0; k < sweeps; k++)
            for (longint x = 1; x < n - 1; x++)
                for (longint y = 0; y < n; y++) begin
                    if (y == 0) begin
                        s = 2 * grid_cells[x*GRID_MAX+1] + grid_cells[(x+1)*GRID_MAX]
                            + grid_cells[(x-1)*GRID_MAX];
                        grid_cells[x*GRID_MAX] = s >>> 2;
                    end else if (y == n - 1) begin
                        s = 2 * grid_cells[x*GRID_MAX+n-2] + grid_cells[(x+1)*GRID_MAX+y]
                            + grid_cells[(x-1)*GRID_MAX+y];
                        grid_cells[x*GRID_MAX+y] = s >>> 2;
                    end else if (off_disc(x, y, cx, cy)) begin
                        s = grid_cells[(x+1)*GRID_MAX+y] + grid_cells[(x-1)*GRID_MAX+y]
                            + grid_cells[x*GRID_MAX+y+1] + grid_cells[x*GRID_MAX+y-1];
                        grid_cells[x*GRID_MAX+y] = s >>> 2;
                    end
                end
    endtask

    task automatic predict_result(in_item_t it);
        out_item_t r;
        longint v, n;
        r = '0;
        if (it.action == ACT_RUN) begin
            fill_and_relax();
            r.result_kind = 1'b0;
        end else begin
            n = grid_edge();
            v = 0;
            if (it.x_index < n && it.y_index < n) v = grid_cells[it.x_index*GRID_MAX+it.y_index];
            r.cell_value = v[VAL_W-1:0];
            r.result_kind = 1'b1;
        end
        pending_results.push_back(r);
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            report("unexpected result", got, 0);
        end else begin
            want = pending_results.pop_front();
            if (got.cell_value !== want.cell_value) report("cell_value", got.cell_value, want.cell_value);
            if (got.result_kind !== want.result_kind)
                report("result_kind", got.result_kind, want.result_kind);
        end
    endtask

    // receiver, watchdog
    always @(posedge aclk) begin
        int r;
        if (aresetn) begin
            if (m_valid && m_ready) check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                r = $urandom_range(0, 99);
                if (hold_req) begin
                    hold_req <= 0;
                    hold_left <= 300;
                    m_ready <= 1'b0;
                end else if (hold_left > 0) begin
                    hold_left <= hold_left - 1;
                    m_ready <= 1'b0;
                end else if (calm || r < 70) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    hold_left <= (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
                end
            end
        end
    end

    task automatic send_request(logic act, logic [IDX_W-1:0] x, logic [IDX_W-1:0] y);
        int g, r;
        in_item_t it;
        r = $urandom_range(0, 99);
        g = (calm || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        it.action = act;
        it.x_index = x;
        it.y_index = y;
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_result(it);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_GRID_SIZE: size_reg = d[SIZE_W-1:0];
            CFG_LEFT:      left_pot = $signed(d);
            CFG_RIGHT:     right_pot = $signed(d);
            CFG_CYL:       cyl_pot = $signed(d);
            CFG_RADIUS:    radius = d[RAD_W-1:0];
            CFG_OFFSET:    offset = $signed(d[OFS_W-1:0]);
            CFG_SWEEPS:    sweeps = d[SWEEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int sz, int l, int r, int c, int rad, int ofs, int sw);
        settle();
        write_reg(CFG_GRID_SIZE, CFG_DATA_W'(sz));
        write_reg(CFG_LEFT, CFG_DATA_W'(l));
        write_reg(CFG_RIGHT, CFG_DATA_W'(r));
        write_reg(CFG_CYL, CFG_DATA_W'(c));
        write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
        write_reg(CFG_OFFSET, CFG_DATA_W'(ofs));
        write_reg(CFG_SWEEPS, CFG_DATA_W'(sw));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_request(ACT_RUN, 0, 0);
        send_request(ACT_READ, 0, 0);
        send_request(ACT_READ, 63, 63);
        send_request(ACT_READ, 63, 0);
    endtask

    task automatic test_plate_extremes();
        set_config(8, 24'h800000, 24'h7FFFFF, 24'h123456, 2, 0, 3);
        send_request(ACT_RUN, 0, 0);
        send_request(ACT_READ, 0, 0);
        send_request(ACT_READ, 7, 7);
        send_request(ACT_READ, 4, 4);
        send_request(ACT_READ, 3, 0);
        send_request(ACT_READ, 8, 2);
        send_request(ACT_READ, 2, 63);
    endtask

    task automatic test_disc_and_saturation();
        set_config(0, 24'h7FFFFF, 24'h800000, 24'hFFFF00, 127, 8'h80, 1);
        send_request(ACT_RUN, 0, 0);
        send_request(ACT_READ, 1, 0);
        send_request(ACT_READ, 1, 2);
        send_request(ACT_READ, 3, 1);
        set_config(127, 24'h000100, 24'hFFFF00, 24'h000000, 10, 8'h7F, 1);
        send_request(ACT_RUN, 0, 0);
        send_request(ACT_READ, 63, 63);
        send_request(ACT_READ, 32, 0);
        set_config(5, 0, 24'h000500, 24'h001000, 1, 8'hFF, 16'hFFFF);
        send_request(ACT_READ, 2, 2);
        send_request(ACT_READ, 4, 4);
    endtask

    task automatic test_backpressure();
        set_config(4, 24'h000400, 24'hFFF000, 24'h000080, 1, 0, 2);
        send_request(ACT_RUN, 0, 0);
        calm = 1;
        hold_req = 1;
        while (hold_left == 0) @(posedge aclk);
        for (int i = 0; i < 6; i++)
            send_request(ACT_READ, IDX_W'($urandom_range(0, 4)), IDX_W'($urandom_range(0, 4)));
        calm = 0;
    endtask

    task automatic test_random_runs();
        int sz, sw, reads;
        for (int p = 0; p < 8; p++) begin
            if ($urandom_range(0, 7) == 0) begin
                sz = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(60, 127);
                sw = $urandom_range(0, 2);
            end else begin
                sz = $urandom_range(3, 12);
                sw = $urandom_range(0, 6);
            end
            calm = (p % 3 == 2);
            set_config(sz, $urandom(), $urandom(), $urandom(), $urandom_range(0, 127),
                       $urandom_range(0, 255), sw);
            send_request(ACT_RUN, IDX_W'($urandom()), IDX_W'($urandom()));
            reads = $urandom_range(8, 14);
            for (int i = 0; i < reads; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_request(ACT_READ, IDX_W'($urandom()), IDX_W'($urandom()));
                else
                    send_request(ACT_READ, IDX_W'($urandom_range(0, grid_edge() - 1)),
                                 IDX_W'($urandom_range(0, grid_edge() - 1)));
            end
        end
        calm = 0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_plate_extremes();
        test_disc_and_saturation();
        test_backpressure();
        test_random_runs();
        settle();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
